>>> rtl/core/quoted_string_unescaper_macros.svh
// Assertion macros for the quoted string unescaper.
// Used by the top level only; needs nothing else.
`ifndef QUOTED_STRING_UNESCAPER_MACROS_SVH
`define QUOTED_STRING_UNESCAPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QSU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/qsu_pkg.sv
// Shared types and constants of the quoted string unescaper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qsu_pkg;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] NUL_BYTE  = 8'h00;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_UNMATCHED = 2'd2
  } kind_t;

  // Results caused by one byte: none, one or two.
  typedef logic [1:0] nres_t;
  localparam nres_t NRES_NONE = 2'd0;
  localparam nres_t NRES_ONE  = 2'd1;
  localparam nres_t NRES_TWO  = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] count;
    logic        last;
  } res_t;

  typedef struct packed {
    nres_t n;
    res_t  r0;
    res_t  r1;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/core/qsu_in_if.sv
// Input byte channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface qsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qsu_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface qsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] consumed_count;
  logic        last;

  modport source (output valid, output kind, output out_byte, output consumed_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input consumed_count,
                  input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qsu_core.sv
// Parser state and per-byte step logic of the quoted string unescaper.
// Depends on qsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsu_core #(
  parameter logic [15:0] COUNT_CAP = 16'hFFFF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic [7:0]    cur_byte,
  input  wire logic          esc_en,
  output qsu_pkg::step_t     step_res
);

  logic        in_string_r, in_string_nxt;
  logic [7:0]  delim_r, delim_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] cnt_bump;

  assign cnt_bump = (cnt_r < COUNT_CAP) ? cnt_r + 16'd1 : cnt_r;

  always_comb begin
    qsu_pkg::res_t blank;
    blank = '{kind: qsu_pkg::KIND_CHAR, data: 8'd0, count: 16'd0, last: 1'b0};

    in_string_nxt = in_string_r;
    delim_nxt     = delim_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    step_res.n    = qsu_pkg::NRES_NONE;
    step_res.r0   = blank;
    step_res.r1   = blank;

    if (!in_string_r) begin
      // opening delimiter, taken unchecked
      delim_nxt     = cur_byte;
      in_string_nxt = 1'b1;
      esc_nxt       = 1'b0;
      cnt_nxt       = 16'd1;
    end else begin
      cnt_nxt = cnt_bump;
      if (cur_byte == qsu_pkg::NUL_BYTE) begin
        step_res.n       = qsu_pkg::NRES_ONE;
        step_res.r0.kind = qsu_pkg::KIND_UNMATCHED;
        step_res.r0.last = 1'b1;
        in_string_nxt    = 1'b0;
        esc_nxt          = 1'b0;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        if (cur_byte == qsu_pkg::BACKSLASH || cur_byte == delim_r) begin
          step_res.n       = qsu_pkg::NRES_ONE;
          step_res.r0.data = cur_byte;
          step_res.r0.last = 1'b1;
        end else begin
          step_res.n       = qsu_pkg::NRES_TWO;
          step_res.r0.data = qsu_pkg::BACKSLASH;
          step_res.r1.data = cur_byte;
          step_res.r1.last = 1'b1;
        end
      end else if (esc_en && cur_byte == qsu_pkg::BACKSLASH) begin
        esc_nxt = 1'b1;
      end else if (cur_byte == delim_r) begin
        step_res.n        = qsu_pkg::NRES_ONE;
        step_res.r0.kind  = qsu_pkg::KIND_DONE;
        step_res.r0.count = cnt_bump;
        step_res.r0.last  = 1'b1;
        in_string_nxt     = 1'b0;
      end else begin
        step_res.n       = qsu_pkg::NRES_ONE;
        step_res.r0.data = cur_byte;
        step_res.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r <= 1'b0;
      delim_r     <= 8'd0;
      esc_r       <= 1'b0;
      cnt_r       <= 16'd0;
    end else if (step_en) begin
      in_string_r <= in_string_nxt;
      delim_r     <= delim_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qsu_obuf.sv
// Two-slot result register: head slot drives the channel, second slot
// holds the trailing byte of an escape pair. Depends on qsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsu_obuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire qsu_pkg::step_t step_res,
  input  wire logic          head_ready,
  output logic               head_valid,
  output qsu_pkg::res_t      head,
  output logic               space
);

  logic          s0_v_r, s1_v_r;
  qsu_pkg::res_t s0_r, s1_r;
  logic          take;

  assign take       = s0_v_r && head_ready;
  assign space      = (!s0_v_r || head_ready) && !s1_v_r;
  assign head_valid = s0_v_r;
  assign head       = s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (load) begin
      s0_v_r <= 1'b1;
      s1_v_r <= (step_res.n == qsu_pkg::NRES_TWO);
    end else if (take) begin
      s0_v_r <= s1_v_r;
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s0_r <= step_res.r0;
      s1_r <= step_res.r1;
    end else if (take) begin
      s0_r <= s1_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/quoted_string_unescaper.sv
// Top level of the quoted string unescaper: input register, step logic and
// result register. Depends on qsu_pkg, qsu_in_if, qsu_out_if, qsu_core, qsu_obuf.
//
// Usage:
//   in_ch  - byte stream, one byte per transfer. The first byte after idle is
//            the delimiter and yields no result; following bytes are unescaped.
//   out_ch - result items: kind (char / done / unmatched), out_byte,
//            consumed_count (done only, saturating) and last, which marks the
//            final result caused by one input byte.
//   cfg_we / cfg_wdata - escape_enable register (reset 1). Write only while
//            the block is idle.
// Path: a byte taken on in_ch passes through the input register, then the
//   result register, before its first result shows on out_ch.
// Throughput: one byte per cycle while out_ch is ready. An escape that emits
//   a backslash plus the byte fills the second slot of the result register,
//   and input holds off until it drains; that second slot is what sets the rate.
// Reset (rst_n low, synchronous): parser idle awaiting a delimiter, count 0,
//   escape_enable 1, both registers empty.
// Receiver stall: the result register holds; the input register still takes
//   one more byte, then in_ch.ready drops until space opens.
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_string_unescaper_macros.svh"

module quoted_string_unescaper #(
  parameter int unsigned MAX_STRING_LENGTH = 65535
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  qsu_in_if.sink      in_ch,
  qsu_out_if.source   out_ch,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata
);

  // Count saturates at the smaller of the length limit and the field range.
  localparam logic [15:0] COUNT_CAP =
    (MAX_STRING_LENGTH < 32'd65535) ? 16'(MAX_STRING_LENGTH) : 16'hFFFF;

  logic           esc_en_r;
  logic           in_v_r;
  logic [7:0]     in_byte_r;
  logic           fire;
  logic           load_res;
  logic           space;
  logic           head_valid;
  logic           ctrl_res;
  logic           mid_res;
  logic           mid_ok;
  qsu_pkg::step_t step_res;
  qsu_pkg::res_t  head;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b1;
    end else if (cfg_we) begin
      esc_en_r <= cfg_wdata;
    end
  end

  // Byte leaves the input register once its results fit; bytes with no
  // result (delimiter, escape start) never wait on the output side.
  assign fire        = in_v_r && ((step_res.n == qsu_pkg::NRES_NONE) || space);
  assign in_ch.ready = !in_v_r || fire;
  assign load_res    = fire && (step_res.n != qsu_pkg::NRES_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  qsu_core #(
    .COUNT_CAP (COUNT_CAP)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (fire),
    .cur_byte (in_byte_r),
    .esc_en   (esc_en_r),
    .step_res (step_res)
  );

  qsu_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load_res),
    .step_res   (step_res),
    .head_ready (out_ch.ready),
    .head_valid (head_valid),
    .head       (head),
    .space      (space)
  );

  assign out_ch.valid          = head_valid;
  assign out_ch.kind           = head.kind;
  assign out_ch.out_byte       = head.data;
  assign out_ch.consumed_count = head.count;
  assign out_ch.last           = head.last;

  // Terms for the checks below.
  assign ctrl_res = out_ch.valid && (out_ch.kind != qsu_pkg::KIND_CHAR);
  assign mid_res  = out_ch.valid && !out_ch.last;
  assign mid_ok   = (out_ch.kind == qsu_pkg::KIND_CHAR) &&
                    (out_ch.out_byte == qsu_pkg::BACKSLASH);

  // A stepped byte with results must show one on the next cycle.
  `QSU_ASSERT_NEXT(a_load_shows, clk, rst_n, load_res, out_ch.valid, "result lost after step")
  // Done and unmatched results always close their byte.
  `QSU_ASSERT_IMPL(a_ctrl_last, clk, rst_n, ctrl_res, out_ch.last, "non-char result not last")
  // Only an escape pair has a non-final result, and it is the backslash.
  `QSU_ASSERT_IMPL(a_pair_head, clk, rst_n, mid_res, mid_ok, "bad escape pair head")

endmodule

`default_nettype wire
